// ===== rtl/core/swrt_pkg.sv =====
// ============================================================================
// swrt_pkg: shared types and constants of the retry tracker
// Request, event and failure codes, the queue entry layout and the
// command/status bundles between controller and datapath.
// ============================================================================
package swrt_pkg;

    // Queue sizing
    localparam int QUEUE_DEPTH = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = 4;

    // Ack timeout: base + step * ring node count, clamped to [min, max] ms
    localparam int TO_W = 14;
    localparam logic [TO_W-1:0] TO_BASE = TO_W'(200);
    localparam logic [TO_W-1:0] TO_STEP = TO_W'(40);
    localparam logic [TO_W-1:0] TO_MIN  = TO_W'(400);
    localparam logic [TO_W-1:0] TO_MAX  = TO_W'(900);

    // Sends allowed before a timeout fails the head
    localparam logic [1:0] MAX_SENDS = 2'd3;

    typedef enum logic [2:0] {
        REQ_SUBMIT    = 3'd0,
        REQ_TICK      = 3'd1,
        REQ_ACK       = 3'd2,
        REQ_CANCEL    = 3'd3,
        REQ_UNCLAIMED = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        EV_NONE = 2'd0,
        EV_SEND = 2'd1,
        EV_DONE = 2'd2,
        EV_FAIL = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        WHY_NONE    = 2'd0,
        WHY_TIMEOUT = 2'd1,
        WHY_UNKNOWN = 2'd2
    } t_why;

    typedef enum logic [1:0] {
        CFG_RING_NODES = 2'd0,
        CFG_PRIO_A     = 2'd1,
        CFG_PRIO_B     = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_APPLY = 2'd2
    } t_state;

    // One pending frame
    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  dst;
        logic [7:0]  ftype;
        logic [1:0]  att;
        logic [31:0] sent_ms;
    } t_entry;

    // Controller -> datapath
    typedef struct packed {
        logic load;
        logic step;
        logic apply;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        logic scan_done;
    } t_dp_status;

endpackage

// ===== rtl/core/swrt_ctrl.sv =====
// ============================================================================
// swrt_ctrl: sequencing controller
// Accepts one item at a time, runs the queue scan until the datapath
// reports it done, then commits the update once the result slot is free.
// ============================================================================
module swrt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  swrt_pkg::t_dp_status i_status,
    output swrt_pkg::t_dp_cmd    o_cmd
);
    import swrt_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    // State and result-valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.scan_done) begin
                    n_state = S_APPLY;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_APPLY: begin
                // commit only when the result register can take the item
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.apply = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/swrt_dpath.sv =====
// ============================================================================
// swrt_dpath: queue storage and update datapath
// Holds the entry queue, config registers, the latched request and the
// result register; scans one entry per cycle and shifts the queue on commit.
// ============================================================================
module swrt_dpath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swrt_pkg::t_dp_cmd    i_cmd,
    output swrt_pkg::t_dp_status o_status,
    // request fields
    input  logic [2:0]           i_req_type,
    input  logic [15:0]          i_seq,
    input  logic [7:0]           i_dst,
    input  logic [7:0]           i_frame_type,
    input  logic [31:0]          i_now_ms,
    input  logic [7:0]           i_ack_status,
    // config writes
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [7:0]           i_cfg_data,
    // result fields
    output logic [1:0]           o_event_kind,
    output logic [1:0]           o_fail_reason,
    output logic                 o_accepted,
    output logic [15:0]          o_ev_seq,
    output logic [7:0]           o_ev_dst,
    output logic [7:0]           o_ev_type,
    output logic [7:0]           o_done_status,
    output logic [3:0]           o_queue_count
);
    import swrt_pkg::*;

    function automatic logic is_prio(input logic [7:0] ft, input logic [7:0] a,
                                     input logic [7:0] b);
        return (ft == a) || (ft == b);
    endfunction

    // Config registers
    logic [7:0]      r_ring_nodes, r_prio_a, r_prio_b;
    logic [TO_W-1:0] r_timeout, n_timeout, to_raw;

    // Queue
    t_entry           r_entry [QUEUE_DEPTH];
    t_entry           n_entry [QUEUE_DEPTH];
    t_entry           e_prev  [QUEUE_DEPTH];
    t_entry           e_next  [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_count, n_count;

    // Latched request
    t_req             r_req;
    logic [15:0]      r_seq;
    logic [7:0]       r_dst, r_ftype, r_ast;
    logic [31:0]      r_now;
    logic             r_new_prio;
    logic [CNT_W-1:0] r_idx;

    // Result register
    t_event      r_kind, n_kind;
    t_why        r_why, n_why;
    logic        r_acc, n_acc;
    logic [15:0] r_ev_seq, n_ev_seq;
    logic [7:0]  r_ev_dst, n_ev_dst, r_ev_type, n_ev_type, r_dstat, n_dstat;
    logic [3:0]  r_qcnt;

    // Commit controls
    logic             do_ins, do_drop, head_wr;
    logic [CNT_W-1:0] op_pos;
    logic [1:0]       head_att;
    logic [31:0]      head_ms;
    t_entry           head, e_scan, new_entry;
    logic             need_scan, scan_end, scan_hit, timed_out;
    logic [31:0]      elapsed;

    // Config writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_nodes <= 8'd0;
            r_prio_a     <= 8'd1;
            r_prio_b     <= 8'd2;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_RING_NODES: r_ring_nodes <= i_cfg_data;
                CFG_PRIO_A:     r_prio_a     <= i_cfg_data;
                CFG_PRIO_B:     r_prio_b     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped ack timeout, refreshed every cycle from the ring node count
    always_comb begin
        to_raw    = TO_BASE + TO_W'(r_ring_nodes) * TO_STEP;
        n_timeout = to_raw;
        if (to_raw < TO_MIN) n_timeout = TO_MIN;
        if (to_raw > TO_MAX) n_timeout = TO_MAX;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TO_MIN;
        end else begin
            r_timeout <= n_timeout;
        end
    end

    // Latch the request on accept; scan index walks one entry per step
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req      <= t_req'(i_req_type);
            r_seq      <= i_seq;
            r_dst      <= i_dst;
            r_ftype    <= i_frame_type;
            r_now      <= i_now_ms;
            r_ast      <= i_ack_status;
            r_new_prio <= is_prio(i_frame_type, r_prio_a, r_prio_b);
            // priority inserts start behind an in-flight head
            r_idx      <= (t_req'(i_req_type) == REQ_SUBMIT && r_count != '0 &&
                           r_entry[0].att != 2'd0) ? CNT_W'(1) : '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    // Scan status
    assign head     = r_entry[0];
    assign e_scan   = r_entry[r_idx[IDX_W-1:0]];
    assign scan_end = (r_idx >= r_count);
    assign need_scan = (r_req == REQ_CANCEL) ||
                       (r_req == REQ_SUBMIT && r_new_prio &&
                        r_count < CNT_W'(QUEUE_DEPTH));
    assign scan_hit = (r_req == REQ_CANCEL) ? (e_scan.seq == r_seq)
                                            : !is_prio(e_scan.ftype, r_prio_a, r_prio_b);
    assign o_status.scan_done = !need_scan || scan_end || scan_hit;

    assign elapsed   = r_now - head.sent_ms;
    assign timed_out = (elapsed >= 32'(r_timeout));

    always_comb begin
        new_entry.seq     = r_seq;
        new_entry.dst     = r_dst;
        new_entry.ftype   = r_ftype;
        new_entry.att     = 2'd0;
        new_entry.sent_ms = 32'd0;
    end

    // Request decode: result fields and queue edit
    always_comb begin
        n_kind    = EV_NONE;
        n_why     = WHY_NONE;
        n_acc     = 1'b0;
        n_ev_seq  = 16'd0;
        n_ev_dst  = 8'd0;
        n_ev_type = 8'd0;
        n_dstat   = 8'd0;
        do_ins    = 1'b0;
        do_drop   = 1'b0;
        op_pos    = '0;
        head_wr   = 1'b0;
        head_att  = head.att;
        head_ms   = head.sent_ms;
        unique case (r_req)
            REQ_SUBMIT: begin
                if (r_count < CNT_W'(QUEUE_DEPTH)) begin
                    do_ins = 1'b1;
                    op_pos = r_new_prio ? r_idx : r_count;
                    n_acc  = 1'b1;
                end
            end
            REQ_TICK: begin
                if (r_count != '0) begin
                    if (head.att == 2'd0) begin
                        head_wr  = 1'b1;
                        head_att = 2'd1;
                        head_ms  = r_now;
                        n_kind   = EV_SEND;
                    end else if (timed_out) begin
                        if (head.att >= MAX_SENDS) begin
                            n_kind  = EV_FAIL;
                            n_why   = WHY_TIMEOUT;
                            do_drop = 1'b1;
                        end else begin
                            head_wr  = 1'b1;
                            head_att = head.att + 2'd1;
                            head_ms  = r_now;
                            n_kind   = EV_SEND;
                        end
                    end
                end
            end
            REQ_ACK: begin
                if (r_count != '0 && head.att != 2'd0 && head.seq == r_seq) begin
                    n_kind  = EV_DONE;
                    n_dstat = r_ast;
                    do_drop = 1'b1;
                end
            end
            REQ_CANCEL: begin
                // scan stopped at the first seq match, if any
                if (!scan_end && e_scan.att == 2'd0) begin
                    do_drop = 1'b1;
                    op_pos  = r_idx;
                    n_acc   = 1'b1;
                end
            end
            REQ_UNCLAIMED: begin
                if (r_count != '0 && head.att != 2'd0 && head.seq == r_seq &&
                    head.dst == r_dst) begin
                    n_kind  = EV_FAIL;
                    n_why   = WHY_UNKNOWN;
                    do_drop = 1'b1;
                end
            end
            default: ;
        endcase
        // head events report the head entry
        if (n_kind != EV_NONE) begin
            n_ev_seq  = head.seq;
            n_ev_dst  = head.dst;
            n_ev_type = head.ftype;
        end
        n_count = r_count;
        if (do_ins)  n_count = r_count + CNT_W'(1);
        if (do_drop) n_count = r_count - CNT_W'(1);
    end

    // Neighbor taps for shifting
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_tap
        if (g == 0) begin : g_first
            assign e_prev[g] = r_entry[g];
        end else begin : g_mid
            assign e_prev[g] = r_entry[g-1];
        end
        if (g == QUEUE_DEPTH - 1) begin : g_last
            assign e_next[g] = r_entry[g];
        end else begin : g_body
            assign e_next[g] = r_entry[g+1];
        end
    end

    // Per-entry next value: open a slot, close a gap, or rewrite the head
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            n_entry[i] = r_entry[i];
            if (do_ins) begin
                if (CNT_W'(i) == op_pos) begin
                    n_entry[i] = new_entry;
                end else if (CNT_W'(i) > op_pos) begin
                    n_entry[i] = e_prev[i];
                end
            end
            if (do_drop && CNT_W'(i) >= op_pos) begin
                n_entry[i] = e_next[i];
            end
            if (head_wr && i == 0) begin
                n_entry[i].att     = head_att;
                n_entry[i].sent_ms = head_ms;
            end
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_entry <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.apply) begin
            r_count <= n_count;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_kind    <= n_kind;
            r_why     <= n_why;
            r_acc     <= n_acc;
            r_ev_seq  <= n_ev_seq;
            r_ev_dst  <= n_ev_dst;
            r_ev_type <= n_ev_type;
            r_dstat   <= n_dstat;
            r_qcnt    <= QCNT_W'(n_count);
        end
    end

    assign o_event_kind  = r_kind;
    assign o_fail_reason = r_why;
    assign o_accepted    = r_acc;
    assign o_ev_seq      = r_ev_seq;
    assign o_ev_dst      = r_ev_dst;
    assign o_ev_type     = r_ev_type;
    assign o_done_status = r_dstat;
    assign o_queue_count = r_qcnt;

endmodule

// ===== rtl/core/stop_and_wait_retry_tracker_core.sv =====
// ============================================================================
// stop_and_wait_retry_tracker_core: stop-and-wait retransmit queue
// Ordered queue of pending frames with only the head in flight; every
// accepted item returns exactly one result item.
// ============================================================================
// Each request item passes through the scan and apply states. An item that only
// touches the queue head (tick, ack, returned unclaimed, plain submit) leaves
// the scan at once, while a priority submit or a cancel scans the queue one
// entry per cycle to find the insert point or the matching sequence. The queue
// update and the result are committed together once the result register is
// free, so a result left waiting on o_out_valid holds back the commit of the
// next item but not its acceptance. Configuration writes are taken every cycle
// and should be issued only while no item is in progress; an index beyond the
// three registers is ignored. The ack timeout is 200 ms plus 40 ms per ring
// node, clamped to 400..900 ms, and time differences wrap modulo 2^32.
module stop_and_wait_retry_tracker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [15:0] i_seq,
    input  logic [7:0]  i_dst,
    input  logic [7:0]  i_frame_type,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_ack_status,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_event_kind,
    output logic [1:0]  o_fail_reason,
    output logic        o_accepted,
    output logic [15:0] o_ev_seq,
    output logic [7:0]  o_ev_dst,
    output logic [7:0]  o_ev_type,
    output logic [7:0]  o_done_status,
    output logic [3:0]  o_queue_count,
    // configuration channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import swrt_pkg::*;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;

    // Config registers are always writable
    assign o_cfg_ready = 1'b1;

    swrt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (dp_status),
        .o_cmd       (dp_cmd)
    );

    swrt_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_status      (dp_status),
        .i_req_type    (i_req_type),
        .i_seq         (i_seq),
        .i_dst         (i_dst),
        .i_frame_type  (i_frame_type),
        .i_now_ms      (i_now_ms),
        .i_ack_status  (i_ack_status),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_event_kind  (o_event_kind),
        .o_fail_reason (o_fail_reason),
        .o_accepted    (o_accepted),
        .o_ev_seq      (o_ev_seq),
        .o_ev_dst      (o_ev_dst),
        .o_ev_type     (o_ev_type),
        .o_done_status (o_done_status),
        .o_queue_count (o_queue_count)
    );

endmodule

// ===== rtl/core/swrt_checker.sv =====
// ============================================================================
// swrt_checker: port-level checks for the retry tracker
// Watches the top-level ports and flags inconsistent result items.
// ============================================================================
module swrt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_event_kind,
    input logic [1:0]  o_fail_reason,
    input logic        o_accepted,
    input logic [15:0] o_ev_seq,
    input logic [7:0]  o_ev_dst,
    input logic [7:0]  o_ev_type,
    input logic [7:0]  o_done_status,
    input logic [3:0]  o_queue_count
);
    import swrt_pkg::*;

    // One item in work at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous item still in work");

    // A stalled result keeps its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_event_kind) && $stable(o_ev_seq) &&
             $stable(o_queue_count)))
        else $error("stalled result changed");

    // Fail reason only rides on a fail event
    a_why_only_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind != EV_FAIL) |-> (o_fail_reason == WHY_NONE))
        else $error("fail reason without fail event");

    // Submit/cancel success never coincides with an event; count stays in range
    a_accept_no_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_accepted) |->
            (o_event_kind == EV_NONE && 32'(o_queue_count) <= QUEUE_DEPTH))
        else $error("accepted result carries an event or bad count");

    // No event: identity and status fields read zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_event_kind == EV_NONE) |->
            (o_ev_seq == 16'd0 && o_ev_dst == 8'd0 && o_ev_type == 8'd0 &&
             o_done_status == 8'd0))
        else $error("event fields set without an event");

endmodule

bind stop_and_wait_retry_tracker_core swrt_checker u_swrt_checker (.*);
